@@ rtl/core/sliding_door_motor_sequencer_unit_macros.svh @@
// Assertion macros shared by the door motor sequencer RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef SLIDING_DOOR_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`define SLIDING_DOOR_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property on every clock edge outside reset.
`define SDMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdms invariant violated");
// Checks that a condition in one cycle brings a consequence in the next.
`define SDMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdms sequence check failed");
`else
`define SDMS_ASSERT(lbl, clk, rst_n, prop)
`define SDMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/sdms_pkg.sv @@
// Shared types and constants of the door motor sequencer.
// No dependencies; the top, sdms_cfg and sdms_seq import this package.
`default_nettype none

package sdms_pkg;

    // Event codes of the request action field.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_HALL    = 2'd1;
    localparam logic [1:0] ACT_ENCODER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FAST_BAND    = 2'd0;
    localparam logic [1:0] REG_MIN_SPEED    = 2'd1;
    localparam logic [1:0] REG_WINDOW_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic [6:0]  FAST_BAND_RESET    = 7'd80;
    localparam logic [9:0]  MIN_SPEED_RESET    = 10'd10;
    localparam logic [15:0] WINDOW_TICKS_RESET = 16'd6000;

    // Sequencing constants.
    localparam logic [2:0]  SETTLE_WINDOWS = 3'd5;
    localparam logic [2:0]  PARK_WINDOWS   = 3'd2;
    localparam logic [1:0]  STALL_LIMIT    = 2'd3;
    localparam logic [1:0]  STALL_ZERO_POS = 2'd1;
    localparam logic [1:0]  STALL_MEASURE  = 2'd2;
    localparam logic [14:0] TRAVEL_MAX     = 15'h7fff;

    // Request payload.
    typedef struct packed {
        logic [1:0] action;
        logic       hall_a_level;
        logic       hall_b_level;
        logic       encoder_level;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic               dir_pin;
        logic               drive_pin;
        logic               blink_pin;
        logic               running;
        logic               stopped;
        logic signed [15:0] position_out;
        logic [14:0]        travel_out;
        logic               calibrating_out;
    } t_rsp;

    // Configuration register contents.
    typedef struct packed {
        logic [6:0]  fast_band_pct;
        logic [9:0]  min_speed;
        logic [15:0] window_ticks;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/sdms_chan_if.sv @@
// Valid/ready channel carrying one request or result payload.
// The payload type is set per instance, normally from sdms_pkg.
`default_nettype none

interface sdms_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sliding_door_motor_sequencer_unit.sv @@
// Sliding cabinet door motor sequencer: one request per cycle, one result per request,
// with a request register and a result register around a state update.
// A request is taken every clock cycle while the result side keeps up; each result appears
// once its request has passed through the request register and then the result
// register. The rate is set by the update of the sequencer state, which every
// request reads and writes. The block holds no memory and needs no clearing after reset.
// Configuration registers must be written only while no request is in flight.
// Depends on sdms_pkg, sdms_chan_if, sdms_cfg, sdms_seq and sdms_band.
`default_nettype none

module sliding_door_motor_sequencer_unit #(
    parameter int POSITION_WIDTH = 16,
    parameter int TICK_WIDTH     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    sdms_chan_if.sink        i_req,
    sdms_chan_if.source      o_rsp
);
    import sdms_pkg::*;

    t_cfg cfg;

    // Configuration register file.
    sdms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer pipeline.
    sdms_seq #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .TICK_WIDTH     (TICK_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/core/sdms_cfg.sv @@
// APB-style configuration registers of the door motor sequencer.
// Depends on sdms_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module sdms_cfg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output sdms_pkg::t_cfg        o_cfg
);
    import sdms_pkg::*;

    logic [6:0]  r_fast_band_pct;
    logic [9:0]  r_min_speed;
    logic [15:0] r_window_ticks;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_band_pct <= FAST_BAND_RESET;
            r_min_speed     <= MIN_SPEED_RESET;
            r_window_ticks  <= WINDOW_TICKS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FAST_BAND:    r_fast_band_pct <= pwdata[6:0];
                REG_MIN_SPEED:    r_min_speed     <= pwdata[9:0];
                REG_WINDOW_TICKS: r_window_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_idx)
            REG_FAST_BAND:    prdata = {25'd0, r_fast_band_pct};
            REG_MIN_SPEED:    prdata = {22'd0, r_min_speed};
            REG_WINDOW_TICKS: prdata = {16'd0, r_window_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.fast_band_pct = r_fast_band_pct;
    assign o_cfg.min_speed     = r_min_speed;
    assign o_cfg.window_ticks  = r_window_ticks;

endmodule

`default_nettype wire

@@ rtl/core/sdms_band.sv @@
// Fast-zone test: is the position inside the percent band of the travel length.
// Depends on nothing but its ports; the products stay narrow.
`default_nettype none

module sdms_band #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic signed [POSITION_WIDTH-1:0] i_pos,
    input  wire logic        [14:0]               i_travel,
    input  wire logic        [6:0]                i_pct,
    output logic                                  o_in_band
);
    localparam int CW = (POSITION_WIDTH + 8 > 25) ? POSITION_WIDTH + 8 : 25;

    logic signed [CW-1:0] pos_ext;
    logic signed [CW-1:0] pos_x100;
    logic signed [7:0]    low_pct;
    logic signed [23:0]   travel_ext;
    logic signed [23:0]   lo_prod;
    logic signed [23:0]   hi_prod;

    // 100 * position by shift and add (64 + 32 + 4).
    assign pos_ext  = CW'(i_pos);
    assign pos_x100 = (pos_ext <<< 6) + (pos_ext <<< 5) + (pos_ext <<< 2);

    // Band limits; the lower percent may go negative for a register above 100.
    assign low_pct    = $signed(8'd100) - $signed({1'b0, i_pct});
    assign travel_ext = $signed({9'd0, i_travel});
    assign lo_prod    = 24'(low_pct) * travel_ext;
    assign hi_prod    = $signed({17'd0, i_pct}) * travel_ext;

    assign o_in_band = (pos_x100 >= CW'(lo_prod)) && (pos_x100 <= CW'(hi_prod));

endmodule

`default_nettype wire

@@ rtl/core/sdms_seq.sv @@
// Sequencer datapath: request register, state update, result register.
// Depends on sdms_pkg, sdms_chan_if, sdms_band and the assertion macro header.
`default_nettype none
`include "sliding_door_motor_sequencer_unit_macros.svh"

module sdms_seq #(
    parameter int POSITION_WIDTH = 16,
    parameter int TICK_WIDTH     = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  sdms_pkg::t_cfg i_cfg,
    sdms_chan_if.sink    i_req,
    sdms_chan_if.source  o_rsp
);
    import sdms_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int TW = TICK_WIDTH;
    localparam int WW = (TW > 16) ? TW : 16;
    localparam int DW = PW + 6;
    localparam int AW = (PW + 1 > 16) ? PW + 1 : 16;

    // Pipeline registers.
    logic    r_in_valid;
    t_req    r_in;
    logic    r_out_valid;
    t_rsp    r_out;
    logic    adv;

    // Sequencer state.
    logic [TW-1:0]        r_tick,      n_tick;
    logic [2:0]           r_wc,        n_wc;
    logic signed [PW-1:0] r_pos,       n_pos;
    logic signed [PW-1:0] r_prev,      n_prev;
    logic [14:0]          r_travel,    n_travel;
    logic                 r_forward,   n_forward;
    logic                 r_halted,    n_halted;
    logic                 r_armed,     n_armed;
    logic                 r_seen_a,    n_seen_a;
    logic                 r_seen_b,    n_seen_b;
    logic                 r_first_run, n_first_run;
    logic [1:0]           r_sc,        n_sc;
    logic                 r_timer_on,  n_timer_on;
    logic                 r_dir,       n_dir;
    logic                 r_drive,     n_drive;
    logic                 r_blink,     n_blink;

    // Datapath helpers.
    logic [TW-1:0]        tick_inc;
    logic                 tick_hit;
    logic                 in_band;
    logic                 fast;
    logic signed [DW-1:0] delta;
    logic signed [DW-1:0] d10;
    logic signed [DW-1:0] ms6;
    logic                 stall;
    logic signed [AW-1:0] pos_ext;
    logic [AW-1:0]        abs_pos;
    logic [14:0]          len;
    logic                 hall_a;
    logic                 hall_b;
    logic                 seen_a_now;
    t_rsp                 n_rsp;

    // Handshake: the result register frees the request register.
    assign adv         = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || adv;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Fast-zone band test on the current position.
    sdms_band #(
        .POSITION_WIDTH (PW)
    ) u_band (
        .i_pos     (r_pos),
        .i_travel  (r_travel),
        .i_pct     (i_cfg.fast_band_pct),
        .o_in_band (in_band)
    );

    assign fast     = !r_first_run && in_band;
    assign tick_inc = r_tick + TW'(1);
    assign tick_hit = (WW'(tick_inc) == WW'(i_cfg.window_ticks));

    // Stall test: 10 * delta against 6 * min_speed.
    assign delta = DW'(r_pos) - DW'(r_prev);
    assign d10   = (delta <<< 3) + (delta <<< 1);
    assign ms6   = $signed(DW'({i_cfg.min_speed, 2'b00}) + DW'({i_cfg.min_speed, 1'b0}));
    assign stall = r_forward ? (d10 <= ms6) : (d10 >= -ms6);

    // Travel length: magnitude of the position, saturated.
    assign pos_ext = AW'(r_pos);
    assign abs_pos = r_pos[PW-1] ? AW'(-pos_ext) : AW'(pos_ext);
    assign len     = (abs_pos > AW'(TRAVEL_MAX)) ? TRAVEL_MAX : 15'(abs_pos);

    assign hall_a = !r_in.hall_a_level;
    assign hall_b = !r_in.hall_b_level;

    // Next state for the request in the input register.
    always_comb begin
        n_tick      = r_tick;
        n_wc        = r_wc;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_travel    = r_travel;
        n_forward   = r_forward;
        n_halted    = r_halted;
        n_armed     = r_armed;
        n_seen_a    = r_seen_a;
        n_seen_b    = r_seen_b;
        n_first_run = r_first_run;
        n_sc        = r_sc;
        n_timer_on  = r_timer_on;
        n_dir       = r_dir;
        n_drive     = r_drive;
        n_blink     = r_blink;
        seen_a_now  = r_seen_a || hall_a;

        case (r_in.action)
            ACT_TICK: begin
                if (r_timer_on) begin
                    n_tick  = tick_inc;
                    n_drive = fast ? (tick_inc[1:0] == 2'd0) : (tick_inc[1:0] != 2'd0);
                    // Window end after settling: measure and maybe stall.
                    if (r_wc == SETTLE_WINDOWS && tick_hit) begin
                        n_blink = !r_blink;
                        n_prev  = r_pos;
                        if (stall) begin
                            if (r_first_run && r_sc < STALL_LIMIT) begin
                                n_sc = r_sc + 2'd1;
                            end
                            if (r_first_run && n_sc == STALL_ZERO_POS) begin
                                n_pos  = '0;
                                n_prev = '0;
                            end else if (r_first_run && n_sc == STALL_MEASURE) begin
                                n_travel = len;
                                if (r_pos[PW-1] || r_pos == '0) begin
                                    n_pos  = '0;
                                    n_prev = '0;
                                end
                                n_first_run = 1'b0;
                            end
                            n_tick   = '0;
                            n_wc     = '0;
                            n_halted = 1'b1;
                            n_dir    = r_forward;
                        end
                    end
                    // Window rollover.
                    if (WW'(n_tick) == WW'(i_cfg.window_ticks)) begin
                        n_tick = '0;
                        if (n_wc < SETTLE_WINDOWS) begin
                            n_wc = n_wc + 3'd1;
                        end
                    end
                    // Park after a stall: stop the timer and arm push-to-open.
                    if (n_halted && n_wc == PARK_WINDOWS) begin
                        n_wc       = '0;
                        n_tick     = '0;
                        n_drive    = 1'b1;
                        n_pos      = r_forward ? $signed(PW'(r_travel)) : '0;
                        n_timer_on = 1'b0;
                        n_armed    = 1'b1;
                    end
                end
            end
            ACT_HALL: begin
                // The second sensor to fire picks the direction.
                if (r_halted && r_armed) begin
                    if (hall_a && r_seen_b) begin
                        n_armed    = 1'b0;
                        n_halted   = 1'b0;
                        n_forward  = 1'b0;
                        n_dir      = 1'b1;
                        n_timer_on = 1'b1;
                        n_seen_a   = 1'b0;
                        n_seen_b   = 1'b0;
                    end else if (hall_b && seen_a_now) begin
                        n_armed    = 1'b0;
                        n_halted   = 1'b0;
                        n_forward  = 1'b1;
                        n_dir      = 1'b0;
                        n_timer_on = 1'b1;
                        n_seen_a   = 1'b0;
                        n_seen_b   = 1'b0;
                    end else begin
                        n_seen_a = seen_a_now;
                        if (hall_b) begin
                            n_seen_b = 1'b1;
                        end
                    end
                end
            end
            ACT_ENCODER: begin
                if (!r_in.encoder_level) begin
                    n_pos = r_forward ? r_pos + PW'(1) : r_pos - PW'(1);
                end
            end
            default: ;
        endcase
    end

    // Result seen after the update.
    always_comb begin
        n_rsp.dir_pin         = n_dir;
        n_rsp.drive_pin       = n_drive;
        n_rsp.blink_pin       = n_blink;
        n_rsp.running         = n_timer_on;
        n_rsp.stopped         = n_halted;
        n_rsp.position_out    = 16'(n_pos);
        n_rsp.travel_out      = n_travel;
        n_rsp.calibrating_out = n_first_run;
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (adv && r_in_valid) begin
            r_out <= n_rsp;
        end
    end

    // State update, one request per cycle while the result side keeps up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_wc        <= '0;
            r_pos       <= '0;
            r_prev      <= '0;
            r_travel    <= '0;
            r_forward   <= 1'b1;
            r_halted    <= 1'b0;
            r_armed     <= 1'b0;
            r_seen_a    <= 1'b0;
            r_seen_b    <= 1'b0;
            r_first_run <= 1'b1;
            r_sc        <= '0;
            r_timer_on  <= 1'b1;
            r_dir       <= 1'b0;
            r_drive     <= 1'b0;
            r_blink     <= 1'b0;
        end else if (adv && r_in_valid) begin
            r_tick      <= n_tick;
            r_wc        <= n_wc;
            r_pos       <= n_pos;
            r_prev      <= n_prev;
            r_travel    <= n_travel;
            r_forward   <= n_forward;
            r_halted    <= n_halted;
            r_armed     <= n_armed;
            r_seen_a    <= n_seen_a;
            r_seen_b    <= n_seen_b;
            r_first_run <= n_first_run;
            r_sc        <= n_sc;
            r_timer_on  <= n_timer_on;
            r_dir       <= n_dir;
            r_drive     <= n_drive;
            r_blink     <= n_blink;
        end
    end

    // The timer only stops while parked, and push-to-open is armed only when halted.
    `SDMS_ASSERT(a_timer_off_halted, i_clk, i_rst_n, r_timer_on || r_halted)
    `SDMS_ASSERT(a_armed_halted, i_clk, i_rst_n, !r_armed || r_halted)
    // Calibration ends exactly on the second stall.
    `SDMS_ASSERT(a_calib_stalls, i_clk, i_rst_n, r_first_run || (r_sc == STALL_MEASURE))
    // A held request is not overwritten while the result side is blocked.
    `SDMS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv,
                      r_in_valid && $stable(r_in))

endmodule

`default_nettype wire
